// ===== rtl/core/ctd_pkg.sv =====
// Shared types and constants for the countdown timer with alarm.
`timescale 1ns / 1ps

package ctd_pkg;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int STAMP_W  = 32;
    localparam int SECS_W   = 16;
    localparam int REM_W    = 31;
    localparam int STEP_W   = 8;
    localparam int DISP_W   = 16;
    localparam int Q60_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Timing constants
    localparam logic [REM_W-1:0] REM_MAX     = {REM_W{1'b1}};
    localparam logic [15:0]      MS_PER_MIN  = 16'd60000;
    localparam logic [9:0]       MS_PER_SEC  = 10'd1000;
    localparam logic [31:0]      ROUND_MS    = 32'd500;
    localparam logic [15:0]      SEC_PER_MIN = 16'd60;
    localparam logic [15:0]      MMSS_SCALE  = 16'd100;

    // Divide by 1000 as (x >> 3) / 125, reciprocal exact for 29-bit operands
    localparam int               DIV8_W      = 29;
    localparam int               RECIP125_W  = 30;
    localparam int               RECIP125_SH = 36;
    localparam logic [RECIP125_W-1:0] RECIP125 = 30'd549755814;

    // Divide by 60 as (s >> 2) / 15, reciprocal exact for 14-bit operands
    localparam int               DIV4_W      = 14;
    localparam int               RECIP15_W   = 15;
    localparam int               RECIP15_SH  = 18;
    localparam logic [RECIP15_W-1:0] RECIP15 = 15'd17477;

    // Event codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_BIG_STEP  = 3'd1,
        CMD_SMALL_STEP = 3'd2,
        CMD_TOGGLE    = 3'd3,
        CMD_RESET     = 3'd4,
        CMD_SET_SECS  = 3'd5,
        CMD_SET_RUN   = 3'd6
    } cmd_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_EN   = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0] BIG_STEP_RST   = 8'd5;
    localparam logic [STEP_W-1:0] SMALL_STEP_RST = 8'd1;

    typedef struct packed {
        logic [STEP_W-1:0] big_step;
        logic [STEP_W-1:0] small_step;
        logic              alarm_en;
    } cfg_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [STAMP_W-1:0] now_ms;
        logic [SECS_W-1:0]  set_seconds;
        logic               run_flag;
    } item_t;

    typedef struct packed {
        logic running;
        logic alarm_on;
        logic alarm_started;
        logic alarm_stopped;
    } status_t;

endpackage

// ===== rtl/core/ctd_state.sv =====
// Timer state update: applies one event to the countdown and alarm state.
`timescale 1ns / 1ps

module ctd_state import ctd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [REM_W-1:0] out_rem_ms,
    output status_t          out_status
);

    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               run_reg, run_next;
    logic               alarm_reg, alarm_next;
    logic               started, stopped;
    logic               v_reg;
    logic [REM_W-1:0]   out_rem_reg;
    status_t            out_status_reg;

    logic [STAMP_W-1:0] delta;
    logic [STEP_W-1:0]  step_min;
    logic [23:0]        step_ms;
    logic [31:0]        step_sum;
    logic [25:0]        secs_ms;
    logic               load;

    assign in_ready = !v_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Arithmetic shared by the event arms
    always_comb begin
        delta    = in_item.now_ms - stamp_reg;
        step_min = (in_item.cmd == CMD_BIG_STEP) ? cfg.big_step : cfg.small_step;
        step_ms  = 24'(step_min) * 24'(MS_PER_MIN);
        step_sum = 32'(rem_reg) + 32'(step_ms);
        secs_ms  = 26'(in_item.set_seconds) * 26'(MS_PER_SEC);
    end

    // Next state for one event
    always_comb begin
        rem_next   = rem_reg;
        stamp_next = stamp_reg;
        run_next   = run_reg;
        alarm_next = alarm_reg;
        started    = 1'b0;
        stopped    = 1'b0;
        unique case (in_item.cmd)
            CMD_TICK: begin
                if (run_reg) begin
                    // zero stamp: no earlier tick, nothing to subtract
                    if (stamp_reg != '0 && rem_reg != '0) begin
                        if (delta >= 32'(rem_reg)) begin
                            rem_next = '0;
                        end else begin
                            rem_next = rem_reg - delta[REM_W-1:0];
                        end
                    end
                    stamp_next = in_item.now_ms;
                end
                if (run_reg && cfg.alarm_en && !alarm_reg && rem_next == '0) begin
                    alarm_next = 1'b1;
                    started    = 1'b1;
                end
                if (alarm_reg && !run_reg && cfg.alarm_en) begin
                    alarm_next = 1'b0;
                    stopped    = 1'b1;
                end
            end
            CMD_BIG_STEP, CMD_SMALL_STEP: begin
                // saturate at the store maximum
                if (step_sum > 32'(REM_MAX)) begin
                    rem_next = REM_MAX;
                end else begin
                    rem_next = step_sum[REM_W-1:0];
                end
            end
            CMD_TOGGLE: begin
                run_next = !run_reg;
            end
            CMD_RESET: begin
                rem_next   = '0;
                stamp_next = '0;
                if (alarm_reg && cfg.alarm_en) begin
                    alarm_next = 1'b0;
                    stopped    = 1'b1;
                end
            end
            CMD_SET_SECS: begin
                rem_next = REM_W'(secs_ms);
            end
            CMD_SET_RUN: begin
                run_next = in_item.run_flag;
            end
            default: begin
            end
        endcase
    end

    // State and stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            stamp_reg <= '0;
            run_reg   <= 1'b0;
            alarm_reg <= 1'b0;
            v_reg     <= 1'b0;
        end else begin
            if (load) begin
                rem_reg   <= rem_next;
                stamp_reg <= stamp_next;
                run_reg   <= run_next;
                alarm_reg <= alarm_next;
                v_reg     <= 1'b1;
            end else if (out_ready) begin
                v_reg <= 1'b0;
            end
        end
    end

    // Snapshot of the state after the event
    always_ff @(posedge aclk) begin
        if (load) begin
            out_rem_reg                  <= rem_next;
            out_status_reg.running       <= run_next;
            out_status_reg.alarm_on      <= alarm_next;
            out_status_reg.alarm_started <= started;
            out_status_reg.alarm_stopped <= stopped;
        end
    end

    assign out_valid  = v_reg;
    assign out_rem_ms = out_rem_reg;
    assign out_status = out_status_reg;

endmodule

// ===== rtl/core/ctd_secs.sv =====
// Rounds remaining milliseconds to whole seconds by reciprocal multiply.
`timescale 1ns / 1ps

module ctd_secs import ctd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REM_W-1:0]  in_rem_ms,
    input  status_t           in_status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SECS_W-1:0] out_seconds,
    output status_t           out_status
);

    localparam int PROD_W = DIV8_W + RECIP125_W;

    logic [31:0]         rounded;
    logic [DIV8_W-1:0]   div8;
    logic [PROD_W-1:0]   prod;
    logic                v_reg;
    logic [SECS_W-1:0]   sec_reg;
    status_t             status_reg;
    logic                load;

    assign in_ready = !v_reg || out_ready;
    assign load     = in_valid && in_ready;

    // (ms + 500) / 1000 = ((ms + 500) >> 3) / 125, kept to 16 bits
    always_comb begin
        rounded = 32'(in_rem_ms) + ROUND_MS;
        div8    = rounded[31:3];
        prod    = PROD_W'(div8) * PROD_W'(RECIP125);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (load) begin
            v_reg <= 1'b1;
        end else if (out_ready) begin
            v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sec_reg    <= prod[RECIP125_SH + SECS_W - 1 : RECIP125_SH];
            status_reg <= in_status;
        end
    end

    assign out_valid   = v_reg;
    assign out_seconds = sec_reg;
    assign out_status  = status_reg;

endmodule

// ===== rtl/core/ctd_disp.sv =====
// MMSS display conversion and the result register.
`timescale 1ns / 1ps

module ctd_disp import ctd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SECS_W-1:0] in_seconds,
    input  status_t           in_status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SECS_W-1:0] out_seconds,
    output logic [DISP_W-1:0] out_mmss,
    output status_t           out_status
);

    localparam int PROD_W = DIV4_W + RECIP15_W;

    logic [DIV4_W-1:0]  div4;
    logic [PROD_W-1:0]  prod;
    logic               b_v_reg;
    logic [SECS_W-1:0]  b_sec_reg;
    logic [Q60_W-1:0]   b_min_reg;
    status_t            b_status_reg;
    logic               b_ready, b_load;

    logic [SECS_W-1:0]  min_x60;
    logic [SECS_W-1:0]  sec_diff;
    logic [DISP_W-1:0]  mmss;
    logic               c_v_reg;
    logic [SECS_W-1:0]  c_sec_reg;
    logic [DISP_W-1:0]  c_mmss_reg;
    status_t            c_status_reg;
    logic               c_ready, c_load;

    assign c_ready  = !c_v_reg || out_ready;
    assign c_load   = b_v_reg && c_ready;
    assign b_ready  = !b_v_reg || c_ready;
    assign b_load   = in_valid && b_ready;
    assign in_ready = b_ready;

    // Minutes: s / 60 = (s >> 2) / 15
    always_comb begin
        div4 = in_seconds[SECS_W-1:2];
        prod = PROD_W'(div4) * PROD_W'(RECIP15);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else begin
            if (b_load) begin
                b_v_reg <= 1'b1;
            end else if (c_ready) begin
                b_v_reg <= 1'b0;
            end
            if (c_load) begin
                c_v_reg <= 1'b1;
            end else if (out_ready) begin
                c_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_sec_reg    <= in_seconds;
            b_min_reg    <= prod[RECIP15_SH + Q60_W - 1 : RECIP15_SH];
            b_status_reg <= in_status;
        end
    end

    // Seconds part and minutes * 100 + seconds, truncated to 16 bits
    always_comb begin
        min_x60  = SECS_W'(b_min_reg) * SEC_PER_MIN;
        sec_diff = b_sec_reg - min_x60;
        mmss     = DISP_W'(b_min_reg) * MMSS_SCALE + DISP_W'(sec_diff[5:0]);
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (c_load) begin
            c_sec_reg    <= b_sec_reg;
            c_mmss_reg   <= mmss;
            c_status_reg <= b_status_reg;
        end
    end

    assign out_valid   = c_v_reg;
    assign out_seconds = c_sec_reg;
    assign out_mmss    = c_mmss_reg;
    assign out_status  = c_status_reg;

endmodule

// ===== rtl/core/countdown_timer_with_alarm.sv =====
// Top level of the millisecond countdown timer with alarm.
`timescale 1ns / 1ps
//
// Event stream in on s_*: s_tuser carries the event code (tick, big step,
// small step, toggle run, reset, set seconds, set running), s_tdata the
// timestamp, new seconds and new running flag. Every accepted word gives
// exactly one result word on m_*: seconds left (rounded), MMSS display,
// running and alarm flags.
// Throughput: one word per cycle while m_tready is high. State is updated
// as each event is loaded, so consecutive events never wait on each other.
// m_tvalid rises once the accepted word has passed the input register,
// state update, divide by 1000, minute split and result register.
// Each stage has its own valid bit; when m_tready is low the stages keep
// filling and s_tready drops only once all five hold a word.
// Configuration (cfg_*) is written with a one-cycle write strobe and should
// change only while no word is in flight.
// Reset (aresetn low, synchronous): time left and stored stamp cleared,
// timer stopped, alarm off, steps back to 5 and 1 minutes, alarm enabled,
// pipeline emptied.

module countdown_timer_with_alarm import ctd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // event input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // now_ms[31:0], set_seconds[47:32], run_flag[48]
    input  logic [CMD_W-1:0]     s_tuser,  // cmd[2:0]
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // seconds_left[15:0], display_mmss[31:16],
                                           // running_now[32], alarm_active[33],
                                           // alarm_started[34], alarm_stopped[35]
);

    cfg_t              cfg_reg;
    logic              in_v_reg;
    item_t             item_reg;
    logic              in_load;

    logic              st_ready, st_valid;
    logic [REM_W-1:0]  st_rem_ms;
    status_t           st_status;

    logic              sec_ready, sec_valid;
    logic [SECS_W-1:0] sec_value;
    status_t           sec_status;

    logic [SECS_W-1:0] out_seconds;
    logic [DISP_W-1:0] out_mmss;
    status_t           out_status;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.big_step   <= BIG_STEP_RST;
            cfg_reg.small_step <= SMALL_STEP_RST;
            cfg_reg.alarm_en   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BIG_STEP:   cfg_reg.big_step   <= cfg_wdata;
                REG_SMALL_STEP: cfg_reg.small_step <= cfg_wdata;
                REG_ALARM_EN:   cfg_reg.alarm_en   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    assign s_tready = !in_v_reg || st_ready;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_load) begin
            in_v_reg <= 1'b1;
        end else if (st_ready) begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            item_reg.cmd         <= cmd_t'(s_tuser);
            item_reg.now_ms      <= s_tdata[31:0];
            item_reg.set_seconds <= s_tdata[47:32];
            item_reg.run_flag    <= s_tdata[48];
        end
    end

    ctd_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (in_v_reg),
        .in_ready   (st_ready),
        .in_item    (item_reg),
        .out_valid  (st_valid),
        .out_ready  (sec_ready),
        .out_rem_ms (st_rem_ms),
        .out_status (st_status)
    );

    logic disp_ready;

    ctd_secs u_secs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (st_valid),
        .in_ready    (sec_ready),
        .in_rem_ms   (st_rem_ms),
        .in_status   (st_status),
        .out_valid   (sec_valid),
        .out_ready   (disp_ready),
        .out_seconds (sec_value),
        .out_status  (sec_status)
    );

    ctd_disp u_disp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (sec_valid),
        .in_ready    (disp_ready),
        .in_seconds  (sec_value),
        .in_status   (sec_status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_seconds (out_seconds),
        .out_mmss    (out_mmss),
        .out_status  (out_status)
    );

    // Result word packing
    assign m_tdata = {4'b0000,
                      out_status.alarm_stopped,
                      out_status.alarm_started,
                      out_status.alarm_on,
                      out_status.running,
                      out_mmss,
                      out_seconds};

endmodule

// ===== rtl/core/ctd_checker.sv =====
// Port-level checks on the timer result stream, bound to the top level.
`timescale 1ns / 1ps

module ctd_checker import ctd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped under stall");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One event cannot both start and stop the alarm
    a_start_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[34] && m_tdata[35]))
        else $error("alarm started and stopped in one word");

    // A started alarm sounds, the timer runs and no time is left
    a_started: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[33] && m_tdata[32] && m_tdata[31:0] == '0)
        else $error("alarm start inconsistent with timer state");

    // A stopped alarm is silent
    a_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35] |-> !m_tdata[33])
        else $error("alarm stopped but still active");

endmodule

bind countdown_timer_with_alarm ctd_checker u_ctd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
